>>> hdl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types and constants of the first-fit block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  // page size is fixed so that the page split is a mask
  localparam int PAGE_BYTES = 4096;
  localparam logic [31:0] PAGE_MASK = 32'(PAGE_BYTES - 1);
  localparam logic [63:0] PAGE_OFFSET_RST = 64'd0 - 64'(PAGE_BYTES);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_RSVD  = 2'd3
  } ffba_op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_REFUSED     = 3'd1,
    ST_EMPTY       = 3'd2,
    ST_DOUBLE_FREE = 3'd3,
    ST_BAD_PTR     = 3'd4
  } ffba_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_HIT,
    S_BUMP_PAGE,
    S_BUMP_BASE,
    S_BUMP_PLACE,
    S_FINISH
  } ffba_state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] request_size;
    logic [63:0] pointer;
  } ffba_in_t;

  typedef struct packed {
    logic [63:0] result_address;
    logic [31:0] alloc_size;
    logic [2:0]  status;
    logic        map_request;
    logic [63:0] map_address;
    logic [32:0] map_length;
  } ffba_out_t;

  typedef struct packed {
    logic [63:0] address;
    logic [31:0] size;
    logic        is_free;
  } ffba_entry_t;

  typedef struct packed {
    logic         load_in;
    logic         scan_start;
    logic         scan_run;
    logic         set_status;
    ffba_status_t status_code;
    logic         reuse;
    logic         mark_free;
    logic         query_hit;
    logic         bump_page;
    logic         bump_base;
    logic         bump_place;
    logic         load_out;
  } ffba_cmd_t;

  typedef struct packed {
    ffba_op_t op;
    logic     req_zero;
    logic     table_full;
    logic     freed_zero;
    logic     none_live;
    logic     ptr_null;
    logic     found;
    logic     exhausted;
    logic     hit_free;
    logic     out_free;
  } ffba_stat_t;

endpackage

`default_nettype wire

>>> hdl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit heap block allocator with a table of live and freed blocks
// ----------------------------------------------------------------------------
// cfg_valid/cfg_data write the heap base address (cfg_ready is always high);
// write it only while the block is idle.
// in_valid/in_ready transfer one request (allocate, free, size query) and
// out_valid/out_ready transfer exactly one result per request.
// sequence: a request with no table search and no append passes through
// decode and finish only. a search reads one entry per cycle through the
// single memory read port; appending a new block adds the page, base and
// place steps of offset arithmetic. one request at a time: in_ready returns
// the cycle after the result is loaded.
// reset: rst_n clears the counts and heap base and presets the page offsets so
// that the first append opens a new page; the table needs no clearing pass.
// stall: a result waits in the output register until taken; the next request
// is accepted meanwhile and waits at its last step for the register.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator #(
  parameter int TABLE_DEPTH = ffba_pkg::TABLE_DEPTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [63:0]            cfg_data,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  ffba_pkg::ffba_in_t     in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output ffba_pkg::ffba_out_t    out_data
);
  import ffba_pkg::*;

  ffba_cmd_t  ctrl_cmd;
  ffba_stat_t dp_stat;

  assign cfg_ready = 1'b1;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd)
  );

  ffba_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (ctrl_cmd),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a request is in progress");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  a_error_no_address: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> (out_data.result_address == 64'd0))
    else $error("failed request returned an address");

  a_map_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.map_request |->
      (out_data.map_address == 64'd0) && (out_data.map_length == 33'd0))
    else $error("map fields set without a map request");

endmodule

`default_nettype wire

>>> hdl/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// sequencer: decodes the operation, runs the table search and bump steps
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  ffba_pkg::ffba_stat_t   stat,
  output ffba_pkg::ffba_cmd_t    cmd
);
  import ffba_pkg::*;

  ffba_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.status_code = ST_OK;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.op)
          OP_ALLOC: begin
            if (stat.req_zero || stat.table_full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_REFUSED;
              state_nxt       = S_FINISH;
            end else if (!stat.freed_zero) begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end else begin
              state_nxt = S_BUMP_PAGE;
            end
          end
          OP_FREE: begin
            if (stat.ptr_null) begin
              state_nxt = S_FINISH;
            end else if (stat.none_live) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_EMPTY;
              state_nxt       = S_FINISH;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          OP_QUERY: begin
            if (stat.none_live) begin
              state_nxt = S_FINISH;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          default: begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_REFUSED;
            state_nxt       = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.found) begin
          state_nxt = S_HIT;
        end else if (stat.exhausted) begin
          case (stat.op)
            OP_ALLOC: state_nxt = S_BUMP_PAGE;
            OP_FREE: begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_BAD_PTR;
              state_nxt       = S_FINISH;
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_HIT: begin
        case (stat.op)
          OP_ALLOC: cmd.reuse = 1'b1;
          OP_FREE: begin
            if (stat.hit_free) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_DOUBLE_FREE;
            end else begin
              cmd.mark_free = 1'b1;
            end
          end
          default: cmd.query_hit = 1'b1;
        endcase
        state_nxt = S_FINISH;
      end
      S_BUMP_PAGE: begin
        cmd.bump_page = 1'b1;
        state_nxt     = S_BUMP_BASE;
      end
      S_BUMP_BASE: begin
        cmd.bump_base = 1'b1;
        state_nxt     = S_BUMP_PLACE;
      end
      S_BUMP_PLACE: begin
        cmd.bump_place = 1'b1;
        state_nxt      = S_FINISH;
      end
      S_FINISH: begin
        // wait for room in the output register
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/ffba_dpath.sv
// ----------------------------------------------------------------------------
// ffba_dpath
// block table memory, counters, heap offsets, result and output registers
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_dpath #(
  parameter int TABLE_DEPTH = ffba_pkg::TABLE_DEPTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire  [63:0]            cfg_data,
  input  ffba_pkg::ffba_in_t     in_data,
  input  ffba_pkg::ffba_cmd_t    cmd,
  output ffba_pkg::ffba_stat_t   stat,
  output logic                   out_valid,
  input  wire                    out_ready,
  output ffba_pkg::ffba_out_t    out_data
);
  import ffba_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  // table memory
  ffba_entry_t mem [TABLE_DEPTH];
  ffba_entry_t rd_data_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  ffba_entry_t       mem_wd;
  logic              rd_en;

  // control state
  logic [CNT_W-1:0]  entry_count_r, entry_count_nxt;
  logic [CNT_W-1:0]  freed_count_r, freed_count_nxt;
  logic [63:0]       page_offset_r, page_offset_nxt;
  logic [32:0]       inpage_offset_r, inpage_offset_nxt;
  logic [63:0]       heap_base_r;
  logic [CNT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              chk_valid_r, chk_valid_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic [1:0]        op_r;
  logic [31:0]       req_r;
  logic [63:0]       ptr_r;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  ffba_entry_t       hit_r, hit_nxt;
  logic [63:0]       base_sum_r, base_sum_nxt;
  logic [63:0]       res_addr_r, res_addr_nxt;
  logic [31:0]       res_size_r, res_size_nxt;
  logic [2:0]        res_status_r, res_status_nxt;
  logic              res_mreq_r, res_mreq_nxt;
  logic [63:0]       res_maddr_r, res_maddr_nxt;
  logic [32:0]       res_mlen_r, res_mlen_nxt;
  ffba_out_t         out_data_r, out_data_nxt;

  logic              match;
  logic              found;
  logic [33:0]       fill_sum;
  logic              overflow;
  logic [31:0]       req_rem;
  logic [31:0]       req_whole;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[scan_idx_r[IDX_W-1:0]];
    end
  end

  always_comb begin
    if (ffba_op_t'(op_r) == OP_ALLOC) begin
      match = rd_data_r.is_free && (rd_data_r.size >= req_r);
    end else begin
      match = (rd_data_r.address == ptr_r);
    end
    found = chk_valid_r && match;

    fill_sum  = {2'b00, req_r} + {1'b0, inpage_offset_r};
    overflow  = fill_sum > 34'(PAGE_BYTES);
    req_rem   = req_r & PAGE_MASK;
    req_whole = req_r & ~PAGE_MASK;
  end

  always_comb begin
    stat.op         = ffba_op_t'(op_r);
    stat.req_zero   = (req_r == 32'd0);
    stat.table_full = (entry_count_r >= DEPTH_CNT);
    stat.freed_zero = (freed_count_r == '0);
    stat.none_live  = (entry_count_r == freed_count_r);
    stat.ptr_null   = (ptr_r == 64'd0);
    stat.found      = found;
    stat.exhausted  = !chk_valid_r && (scan_idx_r >= entry_count_r);
    stat.hit_free   = hit_r.is_free;
    stat.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    entry_count_nxt   = entry_count_r;
    freed_count_nxt   = freed_count_r;
    page_offset_nxt   = page_offset_r;
    inpage_offset_nxt = inpage_offset_r;
    scan_idx_nxt      = scan_idx_r;
    chk_valid_nxt     = chk_valid_r;
    chk_idx_nxt       = chk_idx_r;
    out_valid_nxt     = out_valid_r;
    hit_idx_nxt       = hit_idx_r;
    hit_nxt           = hit_r;
    base_sum_nxt      = base_sum_r;
    res_addr_nxt      = res_addr_r;
    res_size_nxt      = res_size_r;
    res_status_nxt    = res_status_r;
    res_mreq_nxt      = res_mreq_r;
    res_maddr_nxt     = res_maddr_r;
    res_mlen_nxt      = res_mlen_r;
    out_data_nxt      = out_data_r;
    mem_we            = 1'b0;
    mem_wa            = hit_idx_r;
    mem_wd            = hit_r;
    rd_en             = 1'b0;

    if (cmd.load_in) begin
      res_addr_nxt   = '0;
      res_size_nxt   = '0;
      res_status_nxt = ST_OK;
      res_mreq_nxt   = 1'b0;
      res_maddr_nxt  = '0;
      res_mlen_nxt   = '0;
    end

    if (cmd.set_status) begin
      res_status_nxt = cmd.status_code;
    end

    if (cmd.scan_start) begin
      scan_idx_nxt  = '0;
      chk_valid_nxt = 1'b0;
    end

    // one read issued and one entry checked per cycle
    if (cmd.scan_run) begin
      if (scan_idx_r < entry_count_r) begin
        rd_en         = 1'b1;
        chk_valid_nxt = 1'b1;
        chk_idx_nxt   = scan_idx_r[IDX_W-1:0];
        scan_idx_nxt  = scan_idx_r + CNT_ONE;
      end else begin
        chk_valid_nxt = 1'b0;
      end
      if (found) begin
        hit_idx_nxt = chk_idx_r;
        hit_nxt     = rd_data_r;
      end
    end

    if (cmd.reuse) begin
      mem_we          = 1'b1;
      mem_wd.address  = hit_r.address;
      mem_wd.size     = req_r;
      mem_wd.is_free  = 1'b0;
      freed_count_nxt = freed_count_r - CNT_ONE;
      res_addr_nxt    = hit_r.address;
    end

    if (cmd.mark_free) begin
      mem_we          = 1'b1;
      mem_wd.is_free  = 1'b1;
      freed_count_nxt = freed_count_r + CNT_ONE;
    end

    if (cmd.query_hit && !hit_r.is_free) begin
      res_size_nxt = hit_r.size;
    end

    // request spills past the current page: open a new one
    if (cmd.bump_page && overflow) begin
      page_offset_nxt   = page_offset_r + 64'(PAGE_BYTES);
      inpage_offset_nxt = '0;
      res_mreq_nxt      = 1'b1;
      res_mlen_nxt      = {1'b0, req_whole} + 33'(PAGE_BYTES);
    end

    if (cmd.bump_base) begin
      base_sum_nxt = heap_base_r + page_offset_r;
      if (res_mreq_r) begin
        res_maddr_nxt = heap_base_r + page_offset_r;
      end
    end

    if (cmd.bump_place) begin
      mem_we            = 1'b1;
      mem_wa            = entry_count_r[IDX_W-1:0];
      mem_wd.address    = base_sum_r + {31'd0, inpage_offset_r};
      mem_wd.size       = req_r;
      mem_wd.is_free    = 1'b0;
      res_addr_nxt      = base_sum_r + {31'd0, inpage_offset_r};
      inpage_offset_nxt = inpage_offset_r + {1'b0, req_rem};
      page_offset_nxt   = page_offset_r + {32'd0, req_whole};
      entry_count_nxt   = entry_count_r + CNT_ONE;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.result_address = res_addr_r;
      out_data_nxt.alloc_size     = res_size_r;
      out_data_nxt.status         = res_status_r;
      out_data_nxt.map_request    = res_mreq_r;
      out_data_nxt.map_address    = res_maddr_r;
      out_data_nxt.map_length     = res_mlen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r   <= '0;
      freed_count_r   <= '0;
      page_offset_r   <= PAGE_OFFSET_RST;
      inpage_offset_r <= 33'(PAGE_BYTES);
      heap_base_r     <= '0;
      scan_idx_r      <= '0;
      chk_valid_r     <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      entry_count_r   <= entry_count_nxt;
      freed_count_r   <= freed_count_nxt;
      page_offset_r   <= page_offset_nxt;
      inpage_offset_r <= inpage_offset_nxt;
      if (cfg_we) begin
        heap_base_r <= cfg_data;
      end
      scan_idx_r      <= scan_idx_nxt;
      chk_valid_r     <= chk_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_data.operation;
      req_r <= in_data.request_size;
      ptr_r <= in_data.pointer;
    end
    chk_idx_r    <= chk_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_r        <= hit_nxt;
    base_sum_r   <= base_sum_nxt;
    res_addr_r   <= res_addr_nxt;
    res_size_r   <= res_size_nxt;
    res_status_r <= res_status_nxt;
    res_mreq_r   <= res_mreq_nxt;
    res_maddr_r  <= res_maddr_nxt;
    res_mlen_r   <= res_mlen_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
